@@ hw/rtl/osdsu_pkg.sv @@
package osdsu_pkg;

  localparam int STACK_SLOTS_DEF = 64;
  localparam int SLOT_WIDTH_DEF  = 32;

  localparam int MODE_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int DEPTH_W  = 7;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 3;

  localparam logic [MODE_W-1:0] MODE_PUSH    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_POP2    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DUP     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DUP_X1  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_DUP_X2  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DUP2    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DUP2_X1 = 4'd7;
  localparam logic [MODE_W-1:0] MODE_DUP2_X2 = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SWAP    = 4'd9;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_WRITE,
    S_TOP,
    S_TOP_LOAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             known;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] make;
  } op_info_t;

endpackage

@@ hw/rtl/osdsu_cmd_if.sv @@
interface osdsu_cmd_if;
  import osdsu_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink (input valid, input mode, input push_value, output ready);
endinterface

@@ hw/rtl/osdsu_res_if.sv @@
interface osdsu_res_if;
  import osdsu_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  top_value;
  logic [DEPTH_W-1:0]  depth;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output top_value, output depth, output status, input ready);
  modport sink (input valid, input top_value, input depth, input status, output ready);
endinterface

@@ hw/rtl/osdsu_slot_ram.sv @@
module osdsu_slot_ram #(
  parameter int DEPTH = osdsu_pkg::STACK_SLOTS_DEF,
  parameter int WIDTH = osdsu_pkg::SLOT_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ hw/rtl/osdsu_shuffle.sv @@
module osdsu_shuffle #(
  parameter int SLOT_WIDTH = osdsu_pkg::SLOT_WIDTH_DEF
) (
  input  logic [osdsu_pkg::MODE_W-1:0] mode,
  input  logic [osdsu_pkg::CNT_W-1:0]  idx,
  input  logic [SLOT_WIDTH-1:0]        v [4],
  input  logic [SLOT_WIDTH-1:0]        push_value,
  output logic [SLOT_WIDTH-1:0]        wr_data,
  output osdsu_pkg::op_info_t          info
);
  import osdsu_pkg::*;

  logic [1:0] sel;
  logic       use_push;

  // slots consumed and produced
  always_comb begin
    info = '{known: 1'b1, need: 3'd0, make: 3'd0};
    case (mode)
      MODE_PUSH:    info = '{known: 1'b1, need: 3'd0, make: 3'd1};
      MODE_POP:     info = '{known: 1'b1, need: 3'd1, make: 3'd0};
      MODE_POP2:    info = '{known: 1'b1, need: 3'd2, make: 3'd0};
      MODE_DUP:     info = '{known: 1'b1, need: 3'd1, make: 3'd2};
      MODE_DUP_X1:  info = '{known: 1'b1, need: 3'd2, make: 3'd3};
      MODE_DUP_X2:  info = '{known: 1'b1, need: 3'd3, make: 3'd4};
      MODE_DUP2:    info = '{known: 1'b1, need: 3'd2, make: 3'd4};
      MODE_DUP2_X1: info = '{known: 1'b1, need: 3'd3, make: 3'd5};
      MODE_DUP2_X2: info = '{known: 1'b1, need: 3'd4, make: 3'd6};
      MODE_SWAP:    info = '{known: 1'b1, need: 3'd2, make: 3'd2};
      default:      info = '{known: 1'b0, need: 3'd0, make: 3'd0};
    endcase
  end

  // which popped slot lands at each new position, bottom first; v[0] is the old top
  always_comb begin
    sel      = 2'd0;
    use_push = 1'b0;
    case (mode)
      MODE_PUSH: use_push = 1'b1;
      MODE_DUP_X1: begin
        case (idx)
          3'd1:    sel = 2'd1;
          default: sel = 2'd0;
        endcase
      end
      MODE_DUP_X2: begin
        case (idx)
          3'd1:    sel = 2'd2;
          3'd2:    sel = 2'd1;
          default: sel = 2'd0;
        endcase
      end
      MODE_DUP2: begin
        case (idx)
          3'd0, 3'd2: sel = 2'd1;
          default:    sel = 2'd0;
        endcase
      end
      MODE_DUP2_X1: begin
        case (idx)
          3'd0, 3'd3: sel = 2'd1;
          3'd2:       sel = 2'd2;
          default:    sel = 2'd0;
        endcase
      end
      MODE_DUP2_X2: begin
        case (idx)
          3'd0, 3'd4: sel = 2'd1;
          3'd2:       sel = 2'd3;
          3'd3:       sel = 2'd2;
          default:    sel = 2'd0;
        endcase
      end
      MODE_SWAP: begin
        case (idx)
          3'd1:    sel = 2'd1;
          default: sel = 2'd0;
        endcase
      end
      default: sel = 2'd0;
    endcase
  end

  assign wr_data = use_push ? push_value : v[sel];
endmodule

@@ hw/rtl/operand_stack_dup_swap_unit.sv @@
// sequence from command transfer to result valid: a check, then for a legal op a read and a load
// per slot popped and a write per slot produced (the write state is visited even when none is
// produced), then the top read and, when the stack is not empty, a top load
// throughput: one operation at a time; a new command is taken the cycle after the result transfer
// the sequencer moves one slot at a time through the slot memory (separate read and write ports)
// reset: rst clears the depth and the sequencer; the slot memory is not cleared
module operand_stack_dup_swap_unit #(
  parameter int STACK_SLOTS = osdsu_pkg::STACK_SLOTS_DEF,
  parameter int SLOT_WIDTH  = osdsu_pkg::SLOT_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  osdsu_cmd_if.sink   cmd,
  osdsu_res_if.source result
);
  import osdsu_pkg::*;

  localparam int DW = $clog2(STACK_SLOTS + 1);
  localparam int AW = $clog2(STACK_SLOTS);
  localparam int EW = DW + 3;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic [DW-1:0]     depth_q;
  logic [MODE_W-1:0] mode_q;
  logic [SLOT_WIDTH-1:0] pv_q;
  logic [SLOT_WIDTH-1:0] top_q;
  logic [SLOT_WIDTH-1:0] v [4];
  status_t           status_q;

  op_info_t          info;
  logic [SLOT_WIDTH-1:0] sh_data;
  logic [SLOT_WIDTH-1:0] rd_data;

  logic [EW-1:0] depth_ext;
  logic [EW-1:0] need_ext;
  logic [EW-1:0] new_depth;
  logic [EW-1:0] rd_full;
  logic [EW-1:0] wr_full;
  logic          underflow;
  logic          overflow;
  logic          last_read;
  logic          last_write;
  logic          rd_en;
  logic          wr_en;

  osdsu_shuffle #(.SLOT_WIDTH(SLOT_WIDTH)) u_shuffle (
    .mode       (mode_q),
    .idx        (cnt),
    .v          (v),
    .push_value (pv_q),
    .wr_data    (sh_data),
    .info       (info)
  );

  osdsu_slot_ram #(.DEPTH(STACK_SLOTS), .WIDTH(SLOT_WIDTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_full[AW-1:0]),
    .wr_data (sh_data),
    .rd_en   (rd_en),
    .rd_addr (rd_full[AW-1:0]),
    .rd_data (rd_data)
  );

  // shared address arithmetic and bound checks
  assign depth_ext  = EW'(depth_q);
  assign need_ext   = EW'(info.need);
  assign new_depth  = depth_ext + EW'(info.make) - need_ext;
  assign underflow  = depth_ext < need_ext;
  assign overflow   = new_depth > EW'(STACK_SLOTS);
  assign rd_full    = (state == S_TOP) ? depth_ext - EW'(1)
                                       : depth_ext - EW'(1) - EW'(cnt);
  assign wr_full    = depth_ext - need_ext + EW'(cnt);
  assign last_read  = (cnt == info.need - 3'd1);
  assign last_write = (info.make == 3'd0) || (cnt == info.make - 3'd1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd.valid) state_next = S_CHECK;
      S_CHECK: begin
        if (!info.known || underflow || overflow) begin
          state_next = S_TOP;
        end else if (info.need == 3'd0) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ:     state_next = S_LOAD;
      S_LOAD:     state_next = last_read ? S_WRITE : S_READ;
      S_WRITE:    if (last_write) state_next = S_TOP;
      S_TOP:      state_next = (depth_q == '0) ? S_DONE : S_TOP_LOAD;
      S_TOP_LOAD: state_next = S_DONE;
      S_DONE:     if (result.ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    case (state)
      S_READ:  rd_en = 1'b1;
      S_TOP:   rd_en = (depth_q != '0);
      S_WRITE: wr_en = (info.make != 3'd0);
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      depth_q <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CHECK: cnt <= '0;
        S_LOAD:  cnt <= last_read ? '0 : cnt + 3'd1;
        S_WRITE: begin
          if (last_write) begin
            cnt     <= '0;
            depth_q <= new_depth[DW-1:0];
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mode_q <= cmd.mode;
        pv_q   <= SLOT_WIDTH'(cmd.push_value);
      end
      S_CHECK: begin
        if (!info.known) begin
          status_q <= ST_OK;
        end else if (underflow) begin
          status_q <= ST_UNDERFLOW;
        end else if (overflow) begin
          status_q <= ST_OVERFLOW;
        end else begin
          status_q <= ST_OK;
        end
      end
      S_LOAD:     v[cnt[1:0]] <= rd_data;
      S_TOP:      top_q <= '0;
      S_TOP_LOAD: top_q <= rd_data;
      default:    top_q <= top_q;
    endcase
  end

  assign cmd.ready        = (state == S_IDLE);
  assign result.valid     = (state == S_DONE);
  assign result.top_value = VALUE_W'(top_q);
  assign result.depth     = DEPTH_W'(depth_q);
  assign result.status    = status_q;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !cmd.ready)
    else $error("command ready while result pending");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth_ext <= EW'(STACK_SLOTS))
    else $error("stack depth beyond capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_full < EW'(STACK_SLOTS)) && (wr_full >= depth_ext - need_ext))
    else $error("slot write outside the stack");

  a_fault_keeps_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && (underflow || overflow)) |=> $stable(depth_q))
    else $error("faulting operation changed the depth");

  a_underflow_shallow: assert property (@(posedge clk) disable iff (rst)
    (result.valid && status_q == ST_UNDERFLOW) |-> (depth_ext < EW'(4)))
    else $error("underflow reported on a deep stack");
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import osdsu_pkg::*;

  localparam int STACK_SLOTS = STACK_SLOTS_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 25;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd10;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [VALUE_W-1:0] top_value;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } stack_result_t;

  logic clk;
  logic rst;

  osdsu_cmd_if cmd_ch ();
  osdsu_res_if res_ch ();

  operand_stack_dup_swap_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch)
  );

  // shadow stack
  logic [VALUE_W-1:0] shadow_slots [STACK_SLOTS];
  int shadow_depth = 0;
  stack_result_t pending_results [$];

  // stimulus side depth, updated at each command transfer
  int gen_depth = 0;

  int burst_left = 0;
  int max_gap = 0;
  int max_burst = 8;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  int mismatches = 0;
  int n_cmds = 0;
  int n_checked = 0;
  int n_underflow = 0;
  int n_overflow = 0;
  int peak_depth = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void op_shape(input logic [MODE_W-1:0] m, output bit known,
                                   output int need, output int make);
    known = 1'b1;
    need = 0;
    make = 0;
    case (m)
      MODE_PUSH:    begin need = 0; make = 1; end
      MODE_POP:     begin need = 1; make = 0; end
      MODE_POP2:    begin need = 2; make = 0; end
      MODE_DUP:     begin need = 1; make = 2; end
      MODE_DUP_X1:  begin need = 2; make = 3; end
      MODE_DUP_X2:  begin need = 3; make = 4; end
      MODE_DUP2:    begin need = 2; make = 4; end
      MODE_DUP2_X1: begin need = 3; make = 5; end
      MODE_DUP2_X2: begin need = 4; make = 6; end
      MODE_SWAP:    begin need = 2; make = 2; end
      default:      known = 1'b0;
    endcase
  endfunction

  function automatic int depth_after(input logic [MODE_W-1:0] m, input int d);
    bit known;
    int need, make;
    op_shape(m, known, need, make);
    if (!known || d < need || d - need + make > STACK_SLOTS) return d;
    return d - need + make;
  endfunction

  function automatic stack_result_t predict_stack_op(input logic [MODE_W-1:0] m,
                                                     input logic [VALUE_W-1:0] pv);
    logic [VALUE_W-1:0] v1, v2, v3, v4;
    logic [VALUE_W-1:0] r [6];
    bit known;
    int need, make, base;
    stack_result_t res;
    op_shape(m, known, need, make);
    res.status = ST_OK;
    v1 = '0;
    v2 = '0;
    v3 = '0;
    v4 = '0;
    for (int i = 0; i < 6; i++) r[i] = '0;
    if (known) begin
      if (shadow_depth < need) begin
        res.status = ST_UNDERFLOW;
      end else if (shadow_depth - need + make > STACK_SLOTS) begin
        res.status = ST_OVERFLOW;
      end else begin
        base = shadow_depth - need;
        if (need > 0) v1 = shadow_slots[shadow_depth - 1];
        if (need > 1) v2 = shadow_slots[shadow_depth - 2];
        if (need > 2) v3 = shadow_slots[shadow_depth - 3];
        if (need > 3) v4 = shadow_slots[shadow_depth - 4];
        // new slots listed bottom first
        case (m)
          MODE_PUSH:    r[0] = pv;
          MODE_DUP:     begin r[0] = v1; r[1] = v1; end
          MODE_DUP_X1:  begin r[0] = v1; r[1] = v2; r[2] = v1; end
          MODE_DUP_X2:  begin r[0] = v1; r[1] = v3; r[2] = v2; r[3] = v1; end
          MODE_DUP2:    begin r[0] = v2; r[1] = v1; r[2] = v2; r[3] = v1; end
          MODE_DUP2_X1: begin
            r[0] = v2; r[1] = v1; r[2] = v3; r[3] = v2; r[4] = v1;
          end
          MODE_DUP2_X2: begin
            r[0] = v2; r[1] = v1; r[2] = v4; r[3] = v3; r[4] = v2; r[5] = v1;
          end
          MODE_SWAP:    begin r[0] = v1; r[1] = v2; end
          default:      ;
        endcase
        for (int i = 0; i < make; i++) shadow_slots[base + i] = r[i];
        shadow_depth = base + make;
      end
    end
    res.top_value = (shadow_depth == 0) ? '0 : shadow_slots[shadow_depth - 1];
    res.depth = DEPTH_W'(shadow_depth);
    return res;
  endfunction

  // command transfers feed the shadow stack
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      pending_results.push_back(predict_stack_op(cmd_ch.mode, cmd_ch.push_value));
      n_cmds++;
      if (shadow_depth > peak_depth) peak_depth = shadow_depth;
    end
  end

  always @(posedge clk) begin
    stack_result_t exp_res;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: top_value %h depth %0d status %0d",
               res_ch.top_value, res_ch.depth, res_ch.status);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (exp_res.status == ST_UNDERFLOW) n_underflow++;
        if (exp_res.status == ST_OVERFLOW) n_overflow++;
        if (res_ch.top_value !== exp_res.top_value) begin
          $error("top_value: expected %h, actual %h", exp_res.top_value, res_ch.top_value);
          mismatches++;
        end
        if (res_ch.depth !== exp_res.depth) begin
          $error("depth: expected %0d, actual %0d", exp_res.depth, res_ch.depth);
          mismatches++;
        end
        if (res_ch.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, res_ch.status);
          mismatches++;
        end
      end
    end
  end

  // receiver: runs of ready and stall, plus one long hold-off on request
  initial begin
    int run_left;
    logic level;
    run_left = 0;
    level = 1'b1;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          level = ($urandom_range(0, 99) >= stall_pct);
          run_left = $urandom_range(1, 5);
        end
        run_left--;
        res_ch.ready <= level;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] pv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, max_burst);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.push_value <= pv;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    gen_depth = depth_after(m, gen_depth);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic set_pace(input int gap, input int burst, input int stall);
    max_gap = gap;
    max_burst = burst;
    stall_pct = stall;
    burst_left = 0;
  endtask

  // mostly legal ops steered toward a target depth, some raw noise
  task automatic send_random_op(input int target);
    logic [MODE_W-1:0] m;
    bit known;
    int need, make, r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      m = MODE_W'($urandom_range(0, 15));
    end else if (gen_depth < target && r < 65) begin
      m = MODE_PUSH;
    end else if (gen_depth > target && r < 50) begin
      m = $urandom_range(0, 1) ? MODE_POP : MODE_POP2;
    end else begin
      m = MODE_W'($urandom_range(MODE_POP, MODE_SWAP));
      op_shape(m, known, need, make);
      if (gen_depth < need) m = MODE_PUSH;
      else if (gen_depth - need + make > STACK_SLOTS) m = MODE_POP2;
    end
    send_cmd(m, rand_value());
  endtask

  task automatic test_empty_stack();
    for (int m = MODE_POP; m <= MODE_SWAP; m++) send_cmd(MODE_W'(m), rand_value());
    send_cmd(MODE_UNUSED_LO, '1);
    send_cmd(MODE_UNUSED_HI, '0);
  endtask

  task automatic test_shuffles();
    send_cmd(MODE_PUSH, '0);
    send_cmd(MODE_PUSH, '1);
    send_cmd(MODE_PUSH, 32'ha5a5_a5a5);
    send_cmd(MODE_PUSH, 32'h5a5a_5a5a);
    send_cmd(MODE_DUP2_X2, '0);
    send_cmd(MODE_DUP2_X1, '0);
    send_cmd(MODE_DUP_X2, '0);
    send_cmd(MODE_DUP_X1, '0);
    send_cmd(MODE_DUP2, '0);
    send_cmd(MODE_DUP, '0);
    send_cmd(MODE_SWAP, '0);
    send_cmd(MODE_POP, '1);
    send_cmd(MODE_POP2, '1);
  endtask

  task automatic test_full_stack();
    while (gen_depth < STACK_SLOTS) send_cmd(MODE_PUSH, rand_value());
    for (int m = MODE_PUSH; m <= MODE_SWAP; m++) send_cmd(MODE_W'(m), rand_value());
    send_cmd(MODE_UNUSED_HI, rand_value());
    while (gen_depth > STACK_SLOTS - 3) send_cmd(MODE_POP, '0);
    send_cmd(MODE_DUP2_X2, '0);
    send_cmd(MODE_DUP, '0);
    send_cmd(MODE_DUP2, '0);
    while (gen_depth >= 2) send_cmd(MODE_POP2, '0);
    send_cmd(MODE_POP2, '0);
    send_cmd(MODE_SWAP, '0);
    send_cmd(MODE_POP, '0);
  endtask

  task automatic test_backpressure();
    set_pace(0, 8, 0);
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_random_op(24);
  endtask

  task automatic test_random(input int count, input int gap, input int burst, input int stall);
    int target;
    set_pace(gap, burst, stall);
    target = $urandom_range(0, STACK_SLOTS);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0:       target = 0;
          1:       target = STACK_SLOTS;
          default: target = $urandom_range(0, STACK_SLOTS);
        endcase
      end
      send_random_op(target);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= MODE_PUSH;
    cmd_ch.push_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_pace(3, 6, 20);
    test_empty_stack();
    test_shuffles();
    test_full_stack();
    test_backpressure();
    test_random(600, 0, 8, 0);
    test_random(550, 12, 4, 60);
    test_random(450, 4, 10, 25);

    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked (%0d underflow, %0d overflow)",
             n_cmds, n_checked, n_underflow, n_overflow);
    $display("deepest stack seen: %0d of %0d slots", peak_depth, STACK_SLOTS);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/osdsu_pkg.sv
hw/rtl/osdsu_cmd_if.sv
hw/rtl/osdsu_res_if.sv
hw/rtl/osdsu_slot_ram.sv
hw/rtl/osdsu_shuffle.sv
hw/rtl/operand_stack_dup_swap_unit.sv
sim/tb.sv
